[rtl/core/clps_pkg.sv]
`timescale 1ns / 1ps

package clps_pkg;

  // Frame sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRENGTH,
    ST_SUM,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } seq_state_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPACING   = 2'd2;

  // Register widths and reset values
  localparam int THRESH_W  = 16;
  localparam int FLOOR_W   = 8;
  localparam int SPACING_W = 4;
  localparam logic signed [THRESH_W-1:0] THRESH_RESET  = -16'sd186;
  localparam logic        [FLOOR_W-1:0]  FLOOR_RESET   = 8'd1;
  localparam logic        [SPACING_W-1:0] SPACING_RESET = 4'd2;

  // Result field formats
  localparam int PHASE_W       = 4;
  localparam int WEIGHT_FIELDS = 4;
  localparam int WEIGHT_W      = 16;
  localparam int WEIGHT_SHIFT  = 15;
  localparam int MEAN_W        = 14;
  localparam int VAR_W         = 17;
  localparam int MEAN_SHIFT    = 7;
  localparam int VAR_SHIFT     = 6;
  localparam logic [31:0] WEIGHT_ONE = 32'd32768;
  localparam logic [31:0] MEAN_MAX   = 32'd8191;
  localparam logic [31:0] VAR_MAX    = 32'd131071;

endpackage

[rtl/core/clps_if.sv]
`timescale 1ns / 1ps

// Sample channel: one ADC reading per beat
interface clps_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: one result per accepted sample
interface clps_result_if;
  import clps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [PHASE_W-1:0]         drive_pattern;
  logic                       frame_valid;
  logic signed [MEAN_W-1:0]   position_mean;
  logic [VAR_W-1:0]           position_variance;
  logic [WEIGHT_W-1:0]        weight_0;
  logic [WEIGHT_W-1:0]        weight_1;
  logic [WEIGHT_W-1:0]        weight_2;
  logic [WEIGHT_W-1:0]        weight_3;

  modport source (
    output valid, output drive_pattern, output frame_valid, output position_mean,
    output position_variance, output weight_0, output weight_1, output weight_2,
    output weight_3, input ready
  );
  modport sink (
    input valid, input drive_pattern, input frame_valid, input position_mean,
    input position_variance, input weight_0, input weight_1, input weight_2,
    input weight_3, output ready
  );
endinterface

[rtl/core/clps_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
// The caller guarantees dividend < divisor * 2**QW.
module clps_div #(
  parameter int DVD_W = 70,
  parameter int DVS_W = 46,
  parameter int QW    = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [QW-1:0]    quotient
);

  localparam int CMP_W = (DVD_W > DVS_W + QW - 1) ? DVD_W : DVS_W + QW - 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CMP_W-1:0] rem;
  logic [CMP_W-1:0] dsh;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge       = rem >= dsh;
  assign busy     = cnt != '0;
  assign quotient = quo;

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder, shifted divisor, quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CMP_W'(dividend);
      dsh <= CMP_W'(divisor) << (QW - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

[rtl/core/coded_line_position_sensor.sv]
`timescale 1ns / 1ps
// A sample that does not close a frame gives its result beat in the cycle after it
// is taken, and one sample per cycle is accepted while results drain.
// The sample that closes a frame runs strength, sum and multiply steps, then (unless the sum is
// zero) weight, mean and variance divides on the serial divider of QW bits (17 at the defaults).
// Reset (synchronous, rst high) clears phase, accumulators, the sequencer and the result
// valid flag, and loads the register defaults.
module coded_line_position_sensor #(
  parameter int SENSOR_COUNT = 4,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  clps_sample_if.sink                       samples,
  clps_result_if.source                     results,
  input  logic                              wr_en,
  input  logic [clps_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [clps_pkg::CFG_DATA_W-1:0]   wr_data
);
  import clps_pkg::*;

  localparam int ACC_W   = SAMPLE_BITS + 5;
  localparam int STR_W   = SAMPLE_BITS + 4;
  localparam int LOGN    = $clog2(SENSOR_COUNT);
  localparam int SUM_W   = STR_W + LOGN;
  localparam int MAG_W   = SUM_W + LOGN;
  localparam int SX_W    = MAG_W + 1;
  localparam int SXX_W   = SUM_W + 2 * LOGN;
  localparam int OFF_W   = LOGN + 2;
  localparam int OFF2_W  = 2 * LOGN;
  localparam int PW      = MAG_W + SXX_W;
  localparam int DVS_W   = 2 * SUM_W;
  localparam int SP2_W   = 2 * SPACING_W;
  localparam int MSP_W   = MAG_W + SPACING_W;
  localparam int VN_W    = PW + SP2_W;
  localparam int DVD_W   = VN_W + VAR_SHIFT + 1;
  localparam int CW      = (ACC_W > THRESH_W) ? ACC_W : THRESH_W;
  localparam int NW      = (SENSOR_COUNT < WEIGHT_FIELDS) ? SENSOR_COUNT : WEIGHT_FIELDS;
  localparam int SP_MAX  = (1 << SPACING_W) - 1;
  localparam int VAR_BND = (SENSOR_COUNT - 1) * (SENSOR_COUNT - 1) * (1 << VAR_SHIFT)
                           * SP_MAX * SP_MAX + 2;
  localparam int QW_V    = $clog2(VAR_BND);
  localparam int QW      = (QW_V > WEIGHT_W) ? QW_V : WEIGHT_W;
  localparam int SI_W    = $clog2(SENSOR_COUNT);
  localparam int JOB_W   = $clog2(NW + 2);
  localparam int IDX_A   = (SI_W > JOB_W) ? SI_W : JOB_W;
  localparam int IDX_W   = (IDX_A > 3) ? IDX_A : 3;

  // multiply steps and divide jobs
  localparam logic [IDX_W-1:0] MS_SSXX  = IDX_W'(0);
  localparam logic [IDX_W-1:0] MS_MAG2  = IDX_W'(1);
  localparam logic [IDX_W-1:0] MS_S2    = IDX_W'(2);
  localparam logic [IDX_W-1:0] MS_DIFF  = IDX_W'(3);
  localparam logic [IDX_W-1:0] MS_SCALE = IDX_W'(4);
  localparam logic [IDX_W-1:0] JOB_MEAN = IDX_W'(NW);
  localparam logic [IDX_W-1:0] JOB_VAR  = IDX_W'(NW + 1);
  localparam logic [IDX_W-1:0] LAST_SENSOR = IDX_W'(SENSOR_COUNT - 1);

  function automatic logic signed [OFF_W-1:0] sensor_offset(input logic [SI_W-1:0] i);
    return OFF_W'(2 * int'(i) - (SENSOR_COUNT - 1));
  endfunction

  function automatic logic [OFF2_W-1:0] sensor_offset_sq(input logic [SI_W-1:0] i);
    int o;
    o = 2 * int'(i) - (SENSOR_COUNT - 1);
    return OFF2_W'(o * o);
  endfunction

  // configuration
  logic signed [THRESH_W-1:0] thresh;
  logic [FLOOR_W-1:0]         floor_val;
  logic [SPACING_W-1:0]       spacing;

  // sequencer
  seq_state_t       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             div_start;

  // frame state and working registers
  logic [PHASE_W-1:0]      phase;
  logic signed [ACC_W-1:0] acc [SENSOR_COUNT];
  logic [STR_W-1:0]        raw [SENSOR_COUNT];
  logic [STR_W-1:0]        raw_calc [SENSOR_COUNT];
  logic [SUM_W-1:0]        s_acc;
  logic signed [SX_W-1:0]  sx_acc;
  logic [SXX_W-1:0]        sxx_acc;
  logic [PW-1:0]           p_ssxx;
  logic [PW-1:0]           p_mag2;
  logic [DVS_W-1:0]        p_s2;
  logic [SP2_W-1:0]        sp2;
  logic [MSP_W-1:0]        mag_sp;
  logic [VN_W-1:0]         vnum;

  // result register
  logic                     res_valid;
  logic [PHASE_W-1:0]       r_pattern;
  logic                     r_frame;
  logic signed [MEAN_W-1:0] r_mean;
  logic [VAR_W-1:0]         r_var;
  logic [WEIGHT_W-1:0]      r_weight [WEIGHT_FIELDS];

  logic                    in_acc;
  logic [PHASE_W-1:0]      phase_next;
  logic signed [ACC_W-1:0] smp_ext;
  logic                    sx_neg;
  logic [SX_W-1:0]         mag_full;
  logic [MAG_W-1:0]        mag;
  logic [STR_W-1:0]        raw_sel;
  logic [SI_W-1:0]         sensor_idx;
  logic [MAG_W-1:0]        mul_a;
  logic [SXX_W-1:0]        mul_b;
  logic [PW-1:0]           mul_p;
  logic [DVD_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic                    div_busy;
  logic [QW-1:0]           div_q;
  logic [31:0]             q32;
  logic [31:0]             mean_sat;
  logic [VAR_W-1:0]        var_sat;
  logic [MEAN_W-1:0]       mean_mag;

  // handshake
  assign samples.ready = (state == ST_IDLE) && (!res_valid || results.ready);
  assign in_acc        = samples.valid && samples.ready;
  assign phase_next    = phase + 1'b1;
  assign smp_ext       = $signed({{(ACC_W - SAMPLE_BITS){1'b0}}, samples.sample});

  assign results.valid             = res_valid;
  assign results.drive_pattern     = r_pattern;
  assign results.frame_valid       = r_frame;
  assign results.position_mean     = r_mean;
  assign results.position_variance = r_var;
  assign results.weight_0          = r_weight[0];
  assign results.weight_1          = r_weight[1];
  assign results.weight_2          = r_weight[2];
  assign results.weight_3          = r_weight[3];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh    <= THRESH_RESET;
      floor_val <= FLOOR_RESET;
      spacing   <= SPACING_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_THRESHOLD: thresh    <= $signed(wr_data[THRESH_W-1:0]);
        CFG_FLOOR:     floor_val <= wr_data[FLOOR_W-1:0];
        CFG_SPACING:   spacing   <= wr_data[SPACING_W-1:0];
        default:       ;
      endcase
    end
  end

  // per-sensor strength from the closing accumulator
  always_comb begin
    logic signed [ACC_W-1:0] neg_acc;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      neg_acc = -acc[i];
      if (CW'(acc[i]) < CW'(thresh)) begin
        raw_calc[i] = acc[i][ACC_W-1] ? neg_acc[STR_W-1:0] : '0;
      end else begin
        raw_calc[i] = {{(STR_W - FLOOR_W){1'b0}}, floor_val};
      end
    end
  end

  // shared operand selection
  assign sensor_idx = idx[SI_W-1:0];
  assign raw_sel    = (idx < IDX_W'(SENSOR_COUNT)) ? raw[sensor_idx] : '0;
  assign sx_neg     = sx_acc[SX_W-1];
  assign mag_full   = sx_neg ? SX_W'(-sx_acc) : SX_W'(sx_acc);
  assign mag        = mag_full[MAG_W-1:0];

  always_comb begin
    case (idx)
      MS_MAG2: begin
        mul_a = mag;
        mul_b = SXX_W'(mag);
      end
      MS_S2: begin
        mul_a = MAG_W'(s_acc);
        mul_b = SXX_W'(s_acc);
      end
      default: begin
        mul_a = MAG_W'(s_acc);
        mul_b = sxx_acc;
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // divider operands: weights, then mean, then variance
  always_comb begin
    if (idx < JOB_MEAN) begin
      div_dividend = (DVD_W'(raw_sel) << WEIGHT_SHIFT) + (DVD_W'(s_acc) >> 1);
      div_divisor  = DVS_W'(s_acc);
    end else if (idx == JOB_MEAN) begin
      div_dividend = (DVD_W'(mag_sp) << MEAN_SHIFT) + (DVD_W'(s_acc) >> 1);
      div_divisor  = DVS_W'(s_acc);
    end else begin
      div_dividend = (DVD_W'(vnum) << VAR_SHIFT) + (DVD_W'(p_s2) >> 1);
      div_divisor  = p_s2;
    end
  end

  clps_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // quotient saturation
  assign q32      = 32'(div_q);
  assign mean_sat = (q32 > MEAN_MAX) ? (sx_neg ? MEAN_MAX + 32'd1 : MEAN_MAX) : q32;
  assign mean_mag = mean_sat[MEAN_W-1:0];
  assign var_sat  = (q32 > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : q32[VAR_W-1:0];

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    idx_next   = idx;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && (phase_next == '0)) begin
          state_next = ST_STRENGTH;
        end
      end
      ST_STRENGTH: begin
        idx_next   = '0;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (idx == LAST_SENSOR) begin
          idx_next   = '0;
          state_next = ST_MUL;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_MUL: begin
        if (s_acc == '0) begin
          state_next = ST_DONE;
        end else if (idx == MS_SCALE) begin
          idx_next   = '0;
          state_next = ST_DIV_START;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          if (idx == JOB_VAR) begin
            state_next = ST_DONE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_DIV_START;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // phase and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        acc[i] <= '0;
      end
    end else if (in_acc) begin
      phase <= phase_next;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if ((i < PHASE_W) && phase[i % PHASE_W]) begin
          acc[i] <= acc[i] + smp_ext;
        end else begin
          acc[i] <= acc[i] - smp_ext;
        end
      end
    end else if (state == ST_STRENGTH) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        acc[i] <= '0;
      end
    end
  end

  // frame datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_STRENGTH: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          raw[i] <= raw_calc[i];
        end
        s_acc   <= '0;
        sx_acc  <= '0;
        sxx_acc <= '0;
      end
      ST_SUM: begin
        s_acc   <= s_acc + SUM_W'(raw_sel);
        sx_acc  <= sx_acc + SX_W'($signed({1'b0, raw_sel})) * SX_W'(sensor_offset(sensor_idx));
        sxx_acc <= sxx_acc + SXX_W'(raw_sel) * SXX_W'(sensor_offset_sq(sensor_idx));
      end
      ST_MUL: begin
        case (idx)
          MS_SSXX: begin
            p_ssxx <= mul_p;
            sp2    <= SP2_W'(spacing) * SP2_W'(spacing);
            mag_sp <= MSP_W'(mag) * MSP_W'(spacing);
          end
          MS_MAG2:  p_mag2 <= mul_p;
          MS_S2:    p_s2   <= mul_p[DVS_W-1:0];
          MS_DIFF:  p_ssxx <= p_ssxx - p_mag2;
          MS_SCALE: vnum   <= VN_W'(p_ssxx) * VN_W'(sp2);
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

  // result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_acc && (phase_next != '0)) begin
      res_valid <= 1'b1;
    end else if (state == ST_DONE) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_pattern <= phase_next;
      r_frame   <= (phase_next == '0);
      r_mean    <= '0;
      r_var     <= '0;
      for (int k = 0; k < WEIGHT_FIELDS; k++) begin
        r_weight[k] <= '0;
      end
    end else if ((state == ST_DIV_WAIT) && !div_busy) begin
      if (idx < JOB_MEAN) begin
        r_weight[idx[1:0]] <= div_q[WEIGHT_W-1:0];
      end else if (idx == JOB_MEAN) begin
        r_mean <= sx_neg ? $signed(-mean_mag) : $signed(mean_mag);
      end else begin
        r_var <= var_sat;
      end
    end
  end

endmodule

[rtl/core/clps_checker.sv]
`timescale 1ns / 1ps

// Port-level checks on the result channel
module clps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [clps_pkg::PHASE_W-1:0]        drive_pattern,
  input logic                                frame_valid,
  input logic signed [clps_pkg::MEAN_W-1:0]  position_mean,
  input logic [clps_pkg::VAR_W-1:0]          position_variance,
  input logic [clps_pkg::WEIGHT_W-1:0]       weight_0,
  input logic [clps_pkg::WEIGHT_W-1:0]       weight_1,
  input logic [clps_pkg::WEIGHT_W-1:0]       weight_2,
  input logic [clps_pkg::WEIGHT_W-1:0]       weight_3
);
  import clps_pkg::*;

  // a frame closes exactly when the pattern wraps to zero
  a_frame_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_valid == (drive_pattern == '0)))
    else $error("frame flag disagrees with drive pattern");

  // mid-frame beats carry no frame math
  a_mid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> (position_mean == '0) && (position_variance == '0)
      && (weight_0 == '0) && (weight_1 == '0) && (weight_2 == '0) && (weight_3 == '0))
    else $error("nonzero frame fields on a mid-frame beat");

  // normalized weights never exceed one
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_valid |-> (32'(weight_0) <= WEIGHT_ONE) && (32'(weight_1) <= WEIGHT_ONE)
      && (32'(weight_2) <= WEIGHT_ONE) && (32'(weight_3) <= WEIGHT_ONE))
    else $error("weight above one");

  // a stalled result blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("sample taken while result stalled");

  // stalled result beat holds its pattern, mean and variance
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_pattern)
      && $stable(position_variance) && $stable(position_mean))
    else $error("stalled result beat changed");

endmodule

bind coded_line_position_sensor clps_checker u_clps_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (samples.ready),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .drive_pattern     (results.drive_pattern),
  .frame_valid       (results.frame_valid),
  .position_mean     (results.position_mean),
  .position_variance (results.position_variance),
  .weight_0          (results.weight_0),
  .weight_1          (results.weight_1),
  .weight_2          (results.weight_2),
  .weight_3          (results.weight_3)
);
